// ===== hdl/ffha_pkg.sv =====
// ffha_pkg: shared types and constants of the first-fit heap allocator.
// No dependencies.
`timescale 1ns / 1ps

package ffha_pkg;

	localparam int FIELD_W = 32;
	localparam int IN_W = 104;
	localparam int OUT_W = 96;

	localparam logic [31:0] HEAP_BASE_RST = 32'd4096;
	localparam logic [31:0] HEAP_LIMIT_RST = 32'hFFFF_FFFF;

	typedef enum logic [1:0] {
		OP_ALLOC   = 2'd0,
		OP_RELEASE = 2'd1,
		OP_RESIZE  = 2'd2,
		OP_ZALLOC  = 2'd3
	} op_t;

	typedef enum logic {
		CFG_HEAP_BASE  = 1'b0,
		CFG_HEAP_LIMIT = 1'b1
	} cfg_idx_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_MUL,
		S_LAUNCH,
		S_WALK,
		S_ALLOC,
		S_REL,
		S_DONE
	} state_t;

endpackage

// ===== hdl/first_fit_heap_allocator_top.sv =====
// first_fit_heap_allocator_top: controller, break pointer and a chain of table cells.
// Depends on ffha_pkg and ffha_cell.
`timescale 1ns / 1ps

// First-fit heap allocator. For each request a search token walks the whole chain
// of MAX_BLOCKS table cells, one cell per cycle, and a multiply, a launch, an
// allocate step and a release step frame the walk. One request is in flight at a
// time; a finished result waits in the output register while the next request is
// taken. Table entries hold no reset value.
module first_fit_heap_allocator_top import ffha_pkg::*; #(
	parameter int MAX_BLOCKS = 64,
	parameter int HEADER_BYTES = 16,
	parameter int ADDR_BITS = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [IN_W-1:0]  s_tdata,   // operation, size, count, address
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [OUT_W-1:0] m_tdata,   // result_address, copy_length, zero_length
	input  logic             cfg_we,
	input  logic             cfg_index,
	input  logic [31:0]      cfg_data
);

	localparam int IW = $clog2(MAX_BLOCKS);
	localparam int CW = $clog2(MAX_BLOCKS + 1);
	localparam int AW = ADDR_BITS;
	localparam int WW = ((ADDR_BITS > FIELD_W) ? ADDR_BITS : FIELD_W) + 2;

	state_t state_q, state_n;
	op_t op_q;
	logic [FIELD_W-1:0] size_q, count_q, addr_q;
	logic [2*FIELD_W-1:0] prod_q;
	logic [31:0] limit_q;
	logic [AW-1:0] bp_q;
	logic [CW-1:0] cnt_q;
	logic hit_q, fhit_q, rel_q, ov_q;
	logic [IW-1:0] idx_q, fidx_q;
	logic [AW-1:0] start_q, fstart_q;
	logic [FIELD_W-1:0] bytes_q;
	logic [FIELD_W-1:0] res_q, copy_q, zero_q;
	logic [OUT_W-1:0] odata_q;

	logic tv [0:MAX_BLOCKS];
	logic th [0:MAX_BLOCKS];
	logic [IW-1:0] ti [0:MAX_BLOCKS];
	logic [AW-1:0] ts [0:MAX_BLOCKS];
	logic [FIELD_W-1:0] tb [0:MAX_BLOCKS];
	logic tfh [0:MAX_BLOCKS];
	logic [IW-1:0] tfi [0:MAX_BLOCKS];
	logic [AW-1:0] tfs [0:MAX_BLOCKS];

	logic e_we, f_we, f_val;
	logic [IW-1:0] f_idx;
	logic [FIELD_W-1:0] eff_sz;
	logic prod_ok, want_alloc, grow_ok, alloc_ok, pop, fits, out_load;
	logic [WW-1:0] lim, bpx, need, alloc_addr;
	logic [FIELD_W-1:0] res_n, copy_n, zero_n;
	logic rel_n;

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = ov_q;
	assign m_tdata = odata_q;

	assign eff_sz = (op_q == OP_ZALLOC) ? prod_q[FIELD_W-1:0] : size_q;
	assign prod_ok = (count_q != '0) && (size_q != '0) && (prod_q[2*FIELD_W-1:FIELD_W] == '0);
	assign fits = (bytes_q >= size_q);
	assign lim = WW'(AW'(limit_q));
	assign bpx = WW'(bp_q);
	assign need = WW'(HEADER_BYTES) + WW'(eff_sz);
	assign grow_ok = (cnt_q < CW'(MAX_BLOCKS)) && !(bpx > lim) && !(need > (lim - bpx));
	assign alloc_ok = want_alloc && (eff_sz != '0) && (fhit_q || grow_ok);
	assign alloc_addr = (fhit_q ? WW'(fstart_q) : bpx) + WW'(HEADER_BYTES);
	assign pop = rel_q && ((CW'(idx_q) + CW'(1)) == cnt_q);
	assign out_load = (state_q == S_DONE) && (!ov_q || m_tready);

	always_comb begin
		want_alloc = 1'b0;
		res_n = '0;
		copy_n = '0;
		zero_n = '0;
		rel_n = 1'b0;
		case (op_q)
			OP_ALLOC: begin
				want_alloc = 1'b1;
				res_n = alloc_ok ? alloc_addr[FIELD_W-1:0] : '0;
			end
			OP_RELEASE: begin
				rel_n = (addr_q != '0) && hit_q;
			end
			OP_RESIZE: begin
				if ((addr_q == '0) || (size_q == '0)) begin
					want_alloc = 1'b1;
					res_n = alloc_ok ? alloc_addr[FIELD_W-1:0] : '0;
				end else if (hit_q && fits) begin
					res_n = addr_q;
				end else if (hit_q) begin
					want_alloc = 1'b1;
					res_n = alloc_ok ? alloc_addr[FIELD_W-1:0] : '0;
					copy_n = alloc_ok ? bytes_q : '0;
					rel_n = alloc_ok;
				end
			end
			OP_ZALLOC: begin
				want_alloc = prod_ok;
				res_n = alloc_ok ? alloc_addr[FIELD_W-1:0] : '0;
				zero_n = alloc_ok ? eff_sz : '0;
			end
			default: begin
				want_alloc = 1'b0;
			end
		endcase
	end

	always_comb begin
		state_n = state_q;
		case (state_q)
			S_IDLE:   if (s_tvalid) state_n = S_MUL;
			S_MUL:    state_n = S_LAUNCH;
			S_LAUNCH: state_n = S_WALK;
			S_WALK:   if (tv[MAX_BLOCKS]) state_n = S_ALLOC;
			S_ALLOC:  state_n = S_REL;
			S_REL:    state_n = S_DONE;
			S_DONE:   if (!ov_q || m_tready) state_n = S_IDLE;
			default:  state_n = S_IDLE;
		endcase
	end

	always_comb begin
		e_we = (state_q == S_ALLOC) && alloc_ok && !fhit_q;
		f_we = ((state_q == S_ALLOC) && alloc_ok && fhit_q) ||
		       ((state_q == S_REL) && rel_q && !pop);
		f_idx = (state_q == S_ALLOC) ? fidx_q : idx_q;
		f_val = (state_q == S_REL);
	end

	assign tv[0] = (state_q == S_LAUNCH);
	assign th[0] = 1'b0;
	assign ti[0] = '0;
	assign ts[0] = '0;
	assign tb[0] = '0;
	assign tfh[0] = 1'b0;
	assign tfi[0] = '0;
	assign tfs[0] = '0;

	for (genvar g = 0; g < MAX_BLOCKS; g++) begin : g_cell
		ffha_cell #(
			.MAX_BLOCKS(MAX_BLOCKS),
			.HEADER_BYTES(HEADER_BYTES),
			.ADDR_BITS(ADDR_BITS),
			.CELL_IDX(g)
		) u_cell (
			.clk(clk), .arst_n(arst_n), .cnt(cnt_q),
			.addr_key(addr_q), .sz_key(eff_sz),
			.e_we(e_we), .e_idx(cnt_q[IW-1:0]), .e_start(bp_q), .e_bytes(eff_sz),
			.f_we(f_we), .f_idx(f_idx), .f_val(f_val),
			.tv_i(tv[g]), .th_i(th[g]), .ti_i(ti[g]), .ts_i(ts[g]), .tb_i(tb[g]),
			.tfh_i(tfh[g]), .tfi_i(tfi[g]), .tfs_i(tfs[g]),
			.tv_o(tv[g+1]), .th_o(th[g+1]), .ti_o(ti[g+1]), .ts_o(ts[g+1]),
			.tb_o(tb[g+1]), .tfh_o(tfh[g+1]), .tfi_o(tfi[g+1]), .tfs_o(tfs[g+1])
		);
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && s_tvalid) begin
			op_q    <= op_t'(s_tdata[1:0]);
			size_q  <= s_tdata[33:2];
			count_q <= s_tdata[65:34];
			addr_q  <= s_tdata[97:66];
		end
		if (state_q == S_MUL) begin
			prod_q <= count_q * size_q;
		end
		if (state_q == S_WALK && tv[MAX_BLOCKS]) begin
			hit_q    <= th[MAX_BLOCKS];
			idx_q    <= ti[MAX_BLOCKS];
			start_q  <= ts[MAX_BLOCKS];
			bytes_q  <= tb[MAX_BLOCKS];
			fhit_q   <= tfh[MAX_BLOCKS];
			fidx_q   <= tfi[MAX_BLOCKS];
			fstart_q <= tfs[MAX_BLOCKS];
		end
		if (state_q == S_ALLOC) begin
			res_q  <= res_n;
			copy_q <= copy_n;
			zero_q <= zero_n;
			rel_q  <= rel_n;
		end
		if (out_load) begin
			odata_q <= {zero_q, copy_q, res_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ov_q    <= 1'b0;
			cnt_q   <= '0;
			limit_q <= HEAP_LIMIT_RST;
			bp_q    <= AW'(HEAP_BASE_RST);
		end else begin
			state_q <= state_n;
			if (out_load) begin
				ov_q <= 1'b1;
			end else if (m_tready) begin
				ov_q <= 1'b0;
			end
			if (e_we) begin
				cnt_q <= cnt_q + CW'(1);
				bp_q  <= AW'(bpx + need);
			end else if (state_q == S_REL && pop) begin
				cnt_q <= cnt_q - CW'(1);
				bp_q  <= start_q;
			end
			if (cfg_we) begin
				case (cfg_index)
					CFG_HEAP_BASE: begin
						if (cnt_q == '0) bp_q <= AW'(cfg_data);
					end
					CFG_HEAP_LIMIT: limit_q <= cfg_data;
					default: limit_q <= limit_q;
				endcase
			end
		end
	end

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(MAX_BLOCKS)) else $error("table count above capacity");
	a_tok_walk: assert property (@(posedge clk) disable iff (!arst_n)
		tv[MAX_BLOCKS] |-> state_q == S_WALK) else $error("search token out of walk");
	a_accept_mul: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> state_q == S_MUL) else $error("transfer not started");
	a_rel_after: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_REL |-> $past(state_q) == S_ALLOC) else $error("release out of order");

endmodule

// ===== hdl/ffha_cell.sv =====
// ffha_cell: one table entry (start, size, free mark) plus one stage of the search token.
// Depends on ffha_pkg.
`timescale 1ns / 1ps

module ffha_cell import ffha_pkg::*; #(
	parameter int MAX_BLOCKS = 64,
	parameter int HEADER_BYTES = 16,
	parameter int ADDR_BITS = 32,
	parameter int CELL_IDX = 0
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic [$clog2(MAX_BLOCKS+1)-1:0]  cnt,
	input  logic [FIELD_W-1:0]               addr_key,
	input  logic [FIELD_W-1:0]               sz_key,
	input  logic                             e_we,
	input  logic [$clog2(MAX_BLOCKS)-1:0]    e_idx,
	input  logic [ADDR_BITS-1:0]             e_start,
	input  logic [FIELD_W-1:0]               e_bytes,
	input  logic                             f_we,
	input  logic [$clog2(MAX_BLOCKS)-1:0]    f_idx,
	input  logic                             f_val,
	input  logic                             tv_i,
	input  logic                             th_i,
	input  logic [$clog2(MAX_BLOCKS)-1:0]    ti_i,
	input  logic [ADDR_BITS-1:0]             ts_i,
	input  logic [FIELD_W-1:0]               tb_i,
	input  logic                             tfh_i,
	input  logic [$clog2(MAX_BLOCKS)-1:0]    tfi_i,
	input  logic [ADDR_BITS-1:0]             tfs_i,
	output logic                             tv_o,
	output logic                             th_o,
	output logic [$clog2(MAX_BLOCKS)-1:0]    ti_o,
	output logic [ADDR_BITS-1:0]             ts_o,
	output logic [FIELD_W-1:0]               tb_o,
	output logic                             tfh_o,
	output logic [$clog2(MAX_BLOCKS)-1:0]    tfi_o,
	output logic [ADDR_BITS-1:0]             tfs_o
);

	localparam int IW = $clog2(MAX_BLOCKS);
	localparam int CW = $clog2(MAX_BLOCKS + 1);
	localparam int WW = ((ADDR_BITS > FIELD_W) ? ADDR_BITS : FIELD_W) + 2;

	logic [ADDR_BITS-1:0] start_q;
	logic [FIELD_W-1:0]   bytes_q;
	logic                 free_q;
	logic                 used;
	logic                 mhit;
	logic                 mfit;

	assign used = CW'(CELL_IDX) < cnt;
	assign mhit = used && ((WW'(start_q) + WW'(HEADER_BYTES)) == WW'(addr_key));
	assign mfit = used && free_q && (bytes_q >= sz_key);

	always_ff @(posedge clk) begin
		if (e_we && (e_idx == IW'(CELL_IDX))) begin
			start_q <= e_start;
			bytes_q <= e_bytes;
			free_q  <= 1'b0;
		end else if (f_we && (f_idx == IW'(CELL_IDX))) begin
			free_q <= f_val;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tv_o <= 1'b0;
		end else begin
			tv_o <= tv_i;
		end
	end

	// first hit wins: later cells only pass the token on
	always_ff @(posedge clk) begin
		th_o  <= th_i | mhit;
		tfh_o <= tfh_i | mfit;
		if (!th_i && mhit) begin
			ti_o <= IW'(CELL_IDX);
			ts_o <= start_q;
			tb_o <= bytes_q;
		end else begin
			ti_o <= ti_i;
			ts_o <= ts_i;
			tb_o <= tb_i;
		end
		if (!tfh_i && mfit) begin
			tfi_o <= IW'(CELL_IDX);
			tfs_o <= start_q;
		end else begin
			tfi_o <= tfi_i;
			tfs_o <= tfs_i;
		end
	end

endmodule
